// ===== design/ptlp_pkg.sv =====
// shared types and widths for the point to line projection pipeline
package ptlp_pkg;

  // coordinate and datapath widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned EW     = CoordW + 1;          // edge and offset components
  localparam int unsigned PW     = 2 * EW;              // component products
  localparam int unsigned NumW   = PW + 2;              // signed dot product sum
  localparam int unsigned DenW   = 2 * CoordW + 2;      // squared edge length
  localparam int unsigned MagW   = DenW;                // magnitude of the dot product
  localparam int unsigned HalfW  = (MagW + 1) / 2;      // low half for split multiply
  localparam int unsigned HighW  = MagW - HalfW;        // high half for split multiply
  localparam int unsigned PartW  = HalfW + EW;          // partial product width
  localparam int unsigned ProdW  = MagW + EW;           // full product width
  localparam int unsigned DivNW  = ProdW + 1;           // dividend width
  localparam int unsigned DivDW  = DenW + 1;            // divisor width
  localparam int unsigned QuoW   = CoordW + 3;          // quotient bits, one per step
  localparam int unsigned RemW   = DivDW + 1;           // partial remainder width
  localparam int unsigned SumW   = QuoW + 2;            // final add before clamping

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // input item
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t q_x;
    coord_t q_y;
    coord_t q_z;
  } ptlp_in_t;

  // result item
  typedef struct packed {
    coord_t foot_x;
    coord_t foot_y;
    coord_t foot_z;
    logic   degenerate;
    logic   overflow;
  } ptlp_out_t;

  // per item data that rides along the divider
  typedef struct packed {
    logic [2:0][CoordW-1:0] a;
    logic [2:0][CoordW-1:0] q;
    logic                   deg;
    logic                   nneg;
    logic [2:0]             eneg;
  } ptlp_side_t;

  // divider state for the three lanes
  typedef struct packed {
    logic [2:0][RemW-1:0] rem;
    logic [2:0][QuoW-1:0] low;
    logic [2:0][QuoW-1:0] quo;
    logic [DivDW-1:0]     dvs;
  } ptlp_div_t;

endpackage

// ===== design/ptlp_front.sv =====
// front stages: differences, products, dot sums, magnitude and dividend setup
module ptlp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ptlp_pkg::ptlp_in_t item_i,
  output logic              valid_o,
  output ptlp_pkg::ptlp_side_t side_o,
  output ptlp_pkg::ptlp_div_t  div_o
);
  import ptlp_pkg::*;

  logic [2:0][CoordW-1:0] av, bv, qv;
  logic [2:0][EW-1:0]     e1_d, d1_d;

  logic                   v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [2:0][CoordW-1:0] a1_q, q1_q, a2_q, q2_q, a3_q, q3_q, a4_q, q4_q, a5_q, q5_q;
  logic [2:0][EW-1:0]     e1_q, d1_q;

  logic [5:0][PW-1:0]     cr_d, cr_q;
  logic [2:0][PW-1:0]     de_d, de_q, ee_d, ee_q;
  logic [2:0][EW-1:0]     em_d, em2_q, em3_q, em4_q;
  logic [2:0]             eneg2_q, eneg3_q, eneg4_q, eneg5_q;

  logic [NumW-1:0]        num_d, num3_q;
  logic [DenW-1:0]        den_d, den3_q, den4_q, den5_q;
  logic                   deg_d, deg3_q, deg4_q, deg5_q;

  logic [NumW-1:0]        nabs;
  logic [MagW-1:0]        nmag4_q;
  logic                   nneg4_q, nneg5_q;

  logic [2:0][PartW-1:0]  pl_d, ph_d, pl5_q, ph5_q;

  ptlp_div_t              div_d, div_q;
  ptlp_side_t             side_q;

  assign av = {item_i.a_z, item_i.a_y, item_i.a_x};
  assign bv = {item_i.b_z, item_i.b_y, item_i.b_x};
  assign qv = {item_i.q_z, item_i.q_y, item_i.q_x};

  // edge and offset vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = EW'($signed(bv[k])) - EW'($signed(av[k]));
      d1_d[k] = EW'($signed(qv[k])) - EW'($signed(av[k]));
    end
  end

  // cross product terms, dot product terms, edge magnitudes
  always_comb begin
    cr_d[0] = $signed(d1_q[1]) * $signed(e1_q[2]);
    cr_d[1] = $signed(d1_q[2]) * $signed(e1_q[1]);
    cr_d[2] = $signed(d1_q[2]) * $signed(e1_q[0]);
    cr_d[3] = $signed(d1_q[0]) * $signed(e1_q[2]);
    cr_d[4] = $signed(d1_q[0]) * $signed(e1_q[1]);
    cr_d[5] = $signed(d1_q[1]) * $signed(e1_q[0]);
    for (int k = 0; k < 3; k++) begin
      de_d[k] = $signed(d1_q[k]) * $signed(e1_q[k]);
      ee_d[k] = $signed(e1_q[k]) * $signed(e1_q[k]);
      em_d[k] = e1_q[k][EW-1] ? (~e1_q[k] + 1'b1) : e1_q[k];
    end
  end

  // dot sums and zero determinant test
  always_comb begin
    num_d = NumW'($signed(de_q[0])) + NumW'($signed(de_q[1])) + NumW'($signed(de_q[2]));
    den_d = ee_q[0] + ee_q[1] + ee_q[2];
    deg_d = (cr_q[0] == cr_q[1]) && (cr_q[2] == cr_q[3]) && (cr_q[4] == cr_q[5]);
  end

  assign nabs = num3_q[NumW-1] ? (~num3_q + 1'b1) : num3_q;

  // split multiply of the dot magnitude by each edge magnitude
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_d[k] = PartW'(nmag4_q[HalfW-1:0]) * PartW'(em4_q[k]);
      ph_d[k] = PartW'(nmag4_q[MagW-1:HalfW]) * PartW'(em4_q[k]);
    end
  end

  // dividend 2*prod + den, divisor 2*den, dividend leading bits start the remainder
  always_comb begin
    logic [DivNW-1:0] n;
    for (int k = 0; k < 3; k++) begin
      n = (DivNW'(pl5_q[k]) << 1) + (DivNW'(ph5_q[k]) << (HalfW + 1)) + DivNW'(den5_q);
      div_d.rem[k] = RemW'(n[DivNW-1:QuoW]);
      div_d.low[k] = n[QuoW-1:0];
      div_d.quo[k] = '0;
    end
    div_d.dvs = {den5_q, 1'b0};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= av;      q1_q <= qv;      e1_q <= e1_d;    d1_q <= d1_d;
      a2_q <= a1_q;    q2_q <= q1_q;    cr_q <= cr_d;    de_q <= de_d;
      ee_q <= ee_d;    em2_q <= em_d;
      for (int k = 0; k < 3; k++) eneg2_q[k] <= e1_q[k][EW-1];
      a3_q <= a2_q;    q3_q <= q2_q;    num3_q <= num_d; den3_q <= den_d;
      deg3_q <= deg_d; em3_q <= em2_q;  eneg3_q <= eneg2_q;
      a4_q <= a3_q;    q4_q <= q3_q;    nmag4_q <= nabs[MagW-1:0];
      nneg4_q <= num3_q[NumW-1];        den4_q <= den3_q;
      deg4_q <= deg3_q; em4_q <= em3_q; eneg4_q <= eneg3_q;
      a5_q <= a4_q;    q5_q <= q4_q;    pl5_q <= pl_d;   ph5_q <= ph_d;
      den5_q <= den4_q; nneg5_q <= nneg4_q; deg5_q <= deg4_q; eneg5_q <= eneg4_q;
      div_q <= div_d;
      side_q.a <= a5_q;
      side_q.q <= q5_q;
      side_q.deg <= deg5_q;
      side_q.nneg <= nneg5_q;
      side_q.eneg <= eneg5_q;
    end
  end

  assign valid_o = v6_q;
  assign side_o  = side_q;
  assign div_o   = div_q;

endmodule

// ===== design/ptlp_div_step.sv =====
// one restoring division step for all three lanes, registered
module ptlp_div_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ptlp_pkg::ptlp_side_t side_i,
  input  ptlp_pkg::ptlp_div_t  div_i,
  output logic                 valid_o,
  output ptlp_pkg::ptlp_side_t side_o,
  output ptlp_pkg::ptlp_div_t  div_o
);
  import ptlp_pkg::*;

  logic       valid_q;
  ptlp_side_t side_q;
  ptlp_div_t  div_d, div_q;

  // shift in next dividend bit, compare and subtract
  always_comb begin
    logic [RemW-1:0] t;
    logic            ge;
    for (int k = 0; k < 3; k++) begin
      t  = {div_i.rem[k][RemW-2:0], div_i.low[k][QuoW-1]};
      ge = (t >= RemW'(div_i.dvs));
      div_d.rem[k] = ge ? (t - RemW'(div_i.dvs)) : t;
      div_d.low[k] = {div_i.low[k][QuoW-2:0], 1'b0};
      div_d.quo[k] = {div_i.quo[k][QuoW-2:0], ge};
    end
    div_d.dvs = div_i.dvs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign div_o   = div_q;

endmodule

// ===== design/ptlp_back.sv =====
// final stage: signed offset from the first point, clamping, degenerate bypass to q, output register
module ptlp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ptlp_pkg::ptlp_side_t side_i,
  input  ptlp_pkg::ptlp_div_t  div_i,
  output logic                 valid_o,
  output ptlp_pkg::ptlp_out_t  item_o
);
  import ptlp_pkg::*;

  logic                   valid_q;
  ptlp_out_t              item_d, item_q;
  logic [2:0][CoordW-1:0] foot;
  logic [2:0]             sat;

  // foot = a +/- rounded offset, clamped to the coordinate range, or q for a degenerate item
  always_comb begin
    logic signed [SumW-1:0] av, qv, r;
    for (int k = 0; k < 3; k++) begin
      av = SumW'($signed(side_i.a[k]));
      qv = $signed(SumW'(div_i.quo[k]));
      r  = (side_i.nneg ^ side_i.eneg[k]) ? (av - qv) : (av + qv);
      if (r > SumW'(CoordMax)) begin
        foot[k] = CoordMax;
        sat[k]  = 1'b1;
      end else if (r < SumW'(CoordMin)) begin
        foot[k] = CoordMin;
        sat[k]  = 1'b1;
      end else begin
        foot[k] = r[CoordW-1:0];
        sat[k]  = 1'b0;
      end
    end
    if (side_i.deg) begin
      item_d.foot_x     = side_i.q[0];
      item_d.foot_y     = side_i.q[1];
      item_d.foot_z     = side_i.q[2];
      item_d.degenerate = 1'b1;
      item_d.overflow   = 1'b0;
    end else begin
      item_d.foot_x     = foot[0];
      item_d.foot_y     = foot[1];
      item_d.foot_z     = foot[2];
      item_d.degenerate = 1'b0;
      item_d.overflow   = |sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/point_to_line_projection.sv =====
// Point to line projection: foot of the perpendicular from q onto the line through a and b,
// signed Q16.16 in and out, clamped, with degenerate and overflow flags. Fully pipelined:
// one item is accepted every cycle unless the output stalls, and it passes through six front
// stages of subtract, multiply, sum, magnitude, split multiply and dividend setup, then one
// stage per quotient bit of the 35 step restoring divider, then the output stage. The
// whole pipeline holds while a result waits at the output, so ready follows the output side.
module point_to_line_projection (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptlp_pkg::ptlp_in_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptlp_pkg::ptlp_out_t  out_item_o
);
  import ptlp_pkg::*;

  logic                     en;
  logic [QuoW:0]            valid_c;
  ptlp_side_t [QuoW:0]      side_c;
  ptlp_div_t  [QuoW:0]      div_c;

  // pipeline advances whenever the output register is free or being drained
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  ptlp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && en),
    .item_i  (in_item_i),
    .valid_o (valid_c[0]),
    .side_o  (side_c[0]),
    .div_o   (div_c[0])
  );

  // divider chain, one quotient bit per stage
  for (genvar i = 0; i < QuoW; i++) begin : g_div
    ptlp_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .side_i  (side_c[i]),
      .div_i   (div_c[i]),
      .valid_o (valid_c[i+1]),
      .side_o  (side_c[i+1]),
      .div_o   (div_c[i+1])
    );
  end

  ptlp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[QuoW]),
    .side_i  (side_c[QuoW]),
    .div_i   (div_c[QuoW]),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // a degenerate result never reports clamping
  a_deg_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.degenerate |-> !out_item_o.overflow)
    else $error("degenerate item with overflow set");

  // overflow means at least one coordinate sits at a range limit
  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |->
      out_item_o.foot_x == CoordMax || out_item_o.foot_x == CoordMin ||
      out_item_o.foot_y == CoordMax || out_item_o.foot_y == CoordMin ||
      out_item_o.foot_z == CoordMax || out_item_o.foot_z == CoordMin)
    else $error("overflow flagged without a clamped coordinate");

  // a held pipeline keeps the last divider stage unchanged
  a_hold_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_c[QuoW]) && $stable(div_c[QuoW]))
    else $error("divider output moved during a stall");
`endif

endmodule
